[sv/qau_pkg.sv]
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Shared types, command codes and the lane saturation function.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int LW            = 32;   // lane width
  localparam int EW            = 68;   // exact sum width before rounding
  localparam int SQW           = 65;   // sum of squares width
  localparam int NRW           = 33;   // norm width

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_ADD  = 3'd0;
  localparam cmd_t CMD_MUL  = 3'd1;
  localparam cmd_t CMD_CONJ = 3'd2;
  localparam cmd_t CMD_NORM = 3'd3;
  localparam cmd_t CMD_INV  = 3'd4;
  localparam cmd_t CMD_MAT  = 3'd5;

  typedef logic [3:0][LW-1:0]       quat_t;
  typedef logic [2:0][3:0][LW-1:0]  rows3_t;
  typedef logic [3:0][NRW-1:0]      comp_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [2:0] sat;
    rows3_t     fast;
    comp_t      comp;
  } root_side_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [2:0] sat;
    rows3_t     fast;
    logic [3:0] neg;
  } div_side_t;

  typedef struct packed {
    logic [LW-1:0] val;
    logic          clip;
  } sat_t;

  localparam logic signed [EW-1:0] LANE_MAX = EW'(64'sd2147483647);
  localparam logic signed [EW-1:0] LANE_MIN = -LANE_MAX - EW'(1);

  function automatic sat_t sat32(input logic signed [EW-1:0] v);
    sat_t r;
    if (v > LANE_MAX) begin
      r.val  = LANE_MAX[LW-1:0];
      r.clip = 1'b1;
    end else if (v < LANE_MIN) begin
      r.val  = LANE_MIN[LW-1:0];
      r.clip = 1'b1;
    end else begin
      r.val  = v[LW-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

[sv/qau_front.sv]
// ----------------------------------------------------------------------------
// Quaternion front end
// Operand select, products, exact sums with rounding and saturation,
// sum of squares for the norm. Four register stages.
// ----------------------------------------------------------------------------
module qau_front #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  qau_pkg::cmd_t       in_cmd,
  input  qau_pkg::quat_t      in_a,
  input  qau_pkg::quat_t      in_b,
  output logic                o_vld,
  output qau_pkg::cmd_t       o_cmd,
  output qau_pkg::rows3_t     o_fast,
  output logic [2:0]          o_sat,
  output logic [qau_pkg::SQW-1:0] o_s,
  output qau_pkg::comp_t      o_comp
);
  import qau_pkg::*;

  // Hamilton product: b index and sign per product, four per lane
  localparam logic [1:0] HB [16] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2,
                                     2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};
  localparam logic       HN [16] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
                                     1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
  // matrix products: xx yy zz xy xz yz wx wy wz
  localparam logic [1:0] MA [9] = '{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0};
  localparam logic [1:0] MB [9] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2, 2'd3};

  localparam logic signed [EW-1:0] ONE  = EW'(1) <<< (2 * FRAC_BITS);
  localparam logic signed [EW-1:0] HALF = EW'(1) <<< (FRAC_BITS - 1);

  function automatic logic signed [EW-1:0] sx(input logic signed [63:0] p, input logic n);
    logic signed [EW-1:0] v;
    v = EW'(p);
    return n ? -v : v;
  endfunction

  // stage A
  logic   a_vld;
  cmd_t   a_cmd;
  quat_t  a_a, a_b;
  logic [LW-1:0] opa [16];
  logic [LW-1:0] opb [16];

  // stage B
  logic   b_vld;
  cmd_t   b_cmd;
  quat_t  b_a, b_b;
  logic signed [63:0] b_p [16];

  // stage C
  logic   c_vld;
  cmd_t   c_cmd;
  logic signed [EW-1:0] e0_next [3][4];
  logic signed [EW-1:0] e1_next [3][4];
  logic signed [EW-1:0] c_e0 [3][4];
  logic signed [EW-1:0] c_e1 [3][4];
  logic [63:0] c_sq0, c_sq1;
  comp_t  comp_next, c_comp;

  // stage D
  sat_t   st [3][4];
  rows3_t fast_next;
  logic [2:0] sat_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      o_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_vld;
      b_vld <= a_vld;
      c_vld <= b_vld;
      o_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_cmd <= in_cmd;
      a_a   <= in_a;
      a_b   <= in_b;
    end
  end

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      opa[k] = '0;
      opb[k] = '0;
    end
    case (a_cmd)
      CMD_MUL: begin
        for (int k = 0; k < 16; k++) begin
          opa[k] = a_a[2'(k)];
          opb[k] = a_b[HB[k]];
        end
      end
      CMD_MAT: begin
        for (int k = 0; k < 9; k++) begin
          opa[k] = a_a[MA[k]];
          opb[k] = a_a[MB[k]];
        end
      end
      CMD_NORM, CMD_INV: begin
        for (int k = 0; k < 4; k++) begin
          opa[k] = a_a[k];
          opb[k] = a_a[k];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_cmd <= a_cmd;
      b_a   <= a_a;
      b_b   <= a_b;
      for (int k = 0; k < 16; k++) begin
        b_p[k] <= $signed(opa[k]) * $signed(opb[k]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int l = 0; l < 4; l++) begin
        e0_next[r][l] = '0;
        e1_next[r][l] = '0;
      end
    end
    case (b_cmd)
      CMD_ADD: begin
        for (int l = 0; l < 4; l++) begin
          e0_next[0][l] = (EW'($signed(b_a[l])) + EW'($signed(b_b[l]))) <<< FRAC_BITS;
        end
      end
      CMD_CONJ: begin
        e0_next[0][0] = EW'($signed(b_a[0])) <<< FRAC_BITS;
        for (int l = 1; l < 4; l++) begin
          e0_next[0][l] = -(EW'($signed(b_a[l])) <<< FRAC_BITS);
        end
      end
      CMD_MUL: begin
        for (int l = 0; l < 4; l++) begin
          e0_next[0][l] = sx(b_p[4*l], HN[4*l]) + sx(b_p[4*l+1], HN[4*l+1]);
          e1_next[0][l] = sx(b_p[4*l+2], HN[4*l+2]) + sx(b_p[4*l+3], HN[4*l+3]);
        end
      end
      CMD_MAT: begin
        e0_next[0][0] = ONE - ((EW'(b_p[1]) + EW'(b_p[2])) <<< 1);
        e0_next[0][1] = (EW'(b_p[3]) - EW'(b_p[8])) <<< 1;
        e0_next[0][2] = (EW'(b_p[4]) + EW'(b_p[7])) <<< 1;
        e0_next[1][0] = (EW'(b_p[3]) + EW'(b_p[8])) <<< 1;
        e0_next[1][1] = ONE - ((EW'(b_p[0]) + EW'(b_p[2])) <<< 1);
        e0_next[1][2] = (EW'(b_p[5]) - EW'(b_p[6])) <<< 1;
        e0_next[2][0] = (EW'(b_p[4]) - EW'(b_p[7])) <<< 1;
        e0_next[2][1] = (EW'(b_p[5]) + EW'(b_p[6])) <<< 1;
        e0_next[2][2] = ONE - ((EW'(b_p[0]) + EW'(b_p[1])) <<< 1);
      end
      default: ;
    endcase
    for (int l = 0; l < 4; l++) begin
      if (b_cmd == CMD_INV && l > 0) begin
        comp_next[l] = -NRW'($signed(b_a[l]));
      end else begin
        comp_next[l] = NRW'($signed(b_a[l]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_cmd  <= b_cmd;
      c_e0   <= e0_next;
      c_e1   <= e1_next;
      c_sq0  <= b_p[0] + b_p[1];
      c_sq1  <= b_p[2] + b_p[3];
      c_comp <= comp_next;
    end
  end

  always_comb begin
    sat_next = '0;
    for (int r = 0; r < 3; r++) begin
      for (int l = 0; l < 4; l++) begin
        st[r][l]       = sat32((c_e0[r][l] + c_e1[r][l] + HALF) >>> FRAC_BITS);
        fast_next[r][l] = st[r][l].val;
        sat_next[r]    = sat_next[r] | st[r][l].clip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_cmd  <= c_cmd;
      o_fast <= fast_next;
      o_sat  <= sat_next;
      o_s    <= SQW'(c_sq0) + SQW'(c_sq1);
      o_comp <= c_comp;
    end
  end

endmodule

[sv/qau_sqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per register stage, with side data.
// ----------------------------------------------------------------------------
module qau_sqrt #(
  parameter int IW = qau_pkg::SQW,
  parameter int SW = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [IW-1:0]          in_s,
  input  logic [SW-1:0]          in_side,
  output logic                   out_vld,
  output logic [(IW+1)/2-1:0]    out_root,
  output logic [SW-1:0]          out_side
);
  localparam int RW = (IW + 1) / 2;
  localparam int CW = 2 * RW + 1;

  logic          vld_q  [RW];
  logic [IW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [SW-1:0] side_q [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int BI = RW - 1 - s;
    logic          vld_i;
    logic [IW-1:0] rem_i;
    logic [RW-1:0] root_i;
    logic [SW-1:0] side_i;
    logic [CW-1:0] cand;
    logic          take;

    if (s == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = in_s;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_q[s-1];
      assign rem_i  = rem_q[s-1];
      assign root_i = root_q[s-1];
      assign side_i = side_q[s-1];
    end

    // (r + 2^i)^2 - r^2
    assign cand = (CW'(root_i) << (BI + 1)) + (CW'(1) << (2 * BI));
    assign take = CW'(rem_i) >= cand;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= take ? rem_i - cand[IW-1:0] : rem_i;
        root_q[s] <= take ? (root_i | (RW'(1) << BI)) : root_i;
        side_q[s] <= side_i;
      end
    end
  end

  assign out_vld  = vld_q[RW-1];
  assign out_root = root_q[RW-1];
  assign out_side = side_q[RW-1];

endmodule

[sv/qau_div.sv]
// ----------------------------------------------------------------------------
// Pipelined four-lane divider
// Restoring division of four numerators by a shared divisor, one quotient
// bit per register stage, with side data.
// ----------------------------------------------------------------------------
module qau_div #(
  parameter int NW = 48,
  parameter int QW = 17,
  parameter int DW = qau_pkg::NRW,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [3:0][NW-1:0]   in_num,
  input  logic [DW-1:0]        in_den,
  input  logic [SW-1:0]        in_side,
  output logic                 out_vld,
  output logic [3:0][QW-1:0]   out_q,
  output logic [DW-1:0]        out_den,
  output logic [SW-1:0]        out_side
);
  localparam int CW = (NW > QW + DW) ? NW : QW + DW;

  logic                 vld_q  [QW];
  logic [3:0][NW-1:0]   rem_q  [QW];
  logic [3:0][QW-1:0]   quo_q  [QW];
  logic [DW-1:0]        den_q  [QW];
  logic [SW-1:0]        side_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int BI = QW - 1 - s;
    logic               vld_i;
    logic [3:0][NW-1:0] rem_i;
    logic [3:0][QW-1:0] quo_i;
    logic [DW-1:0]      den_i;
    logic [SW-1:0]      side_i;
    logic [CW-1:0]      dsh;
    logic [3:0][NW-1:0] rem_next;
    logic [3:0][QW-1:0] quo_next;

    if (s == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = in_num;
      assign quo_i  = '0;
      assign den_i  = in_den;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_q[s-1];
      assign rem_i  = rem_q[s-1];
      assign quo_i  = quo_q[s-1];
      assign den_i  = den_q[s-1];
      assign side_i = side_q[s-1];
    end

    assign dsh = CW'(den_i) << BI;

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        if (CW'(rem_i[l]) >= dsh) begin
          rem_next[l] = rem_i[l] - dsh[NW-1:0];
          quo_next[l] = quo_i[l] | (QW'(1) << BI);
        end else begin
          rem_next[l] = rem_i[l];
          quo_next[l] = quo_i[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= rem_next;
        quo_q[s]  <= quo_next;
        den_q[s]  <= den_i;
        side_q[s] <= side_i;
      end
    end
  end

  assign out_vld  = vld_q[QW-1];
  assign out_q    = quo_q[QW-1];
  assign out_den  = den_q[QW-1];
  assign out_side = side_q[QW-1];

endmodule

[sv/qau_out.sv]
// ----------------------------------------------------------------------------
// Quaternion output stage
// Result select, sign and saturation of the divided lanes, output register
// and row sequencing for the matrix command.
// ----------------------------------------------------------------------------
module qau_out #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF,
  parameter int QW1       = 17,
  parameter int QW2       = 33
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_vld,
  input  qau_pkg::div_side_t       in_side,
  input  logic [qau_pkg::NRW-1:0]  in_den,
  input  logic [3:0][QW1-1:0]      in_q1,
  input  logic [3:0][QW2-1:0]      in_q2,
  output logic                     adv,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [127:0]             m_tdata,
  output logic [3:0]               m_tuser,
  output logic                     m_tlast
);
  import qau_pkg::*;

  logic signed [EW-1:0] v1 [4];
  logic signed [EW-1:0] v2 [4];
  sat_t                 st [4];

  logic [3:0][3:0][LW-1:0] rows_next;
  logic [3:0]              sat_next;
  logic                    dive_next;
  logic                    mat_next;
  logic                    load_next;

  logic                    o_vld;
  logic                    o_mat;
  logic [1:0]              o_beat;
  logic [3:0][3:0][LW-1:0] o_rows;
  logic [3:0]              o_sat;
  logic                    o_dive;
  logic                    last_beat;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      v1[l] = EW'($signed({1'b0, in_q1[l]}));
      v2[l] = EW'($signed({1'b0, in_q2[l]}));
      if (in_side.neg[l]) begin
        v1[l] = -v1[l];
        v2[l] = -v2[l];
      end
      st[l] = sat32((in_side.cmd == CMD_INV) ? v2[l] : v1[l]);
    end
  end

  always_comb begin
    rows_next = '0;
    sat_next  = '0;
    dive_next = 1'b0;
    mat_next  = (in_side.cmd == CMD_MAT);
    load_next = in_vld && (in_side.cmd inside {[CMD_ADD:CMD_MAT]});
    if (in_side.cmd inside {CMD_NORM, CMD_INV}) begin
      if (in_den == '0) begin
        dive_next = 1'b1;
      end else begin
        for (int l = 0; l < 4; l++) begin
          rows_next[0][l] = st[l].val;
          sat_next[0]     = sat_next[0] | st[l].clip;
        end
      end
    end else begin
      rows_next[2:0]  = in_side.fast;
      sat_next[2:0]   = in_side.sat;
      rows_next[3][3] = LW'(1) << FRAC_BITS;
    end
  end

  assign last_beat = !o_mat || (o_beat == 2'd3);
  assign adv       = !o_vld || (m_tready && last_beat);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld  <= 1'b0;
      o_mat  <= 1'b0;
      o_beat <= '0;
    end else if (adv) begin
      o_vld  <= load_next;
      o_mat  <= mat_next;
      o_beat <= '0;
    end else if (m_tready) begin
      o_beat <= o_beat + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_rows <= rows_next;
      o_sat  <= sat_next;
      o_dive <= dive_next;
    end
  end

  assign m_tvalid = o_vld;
  assign m_tdata  = o_rows[o_beat];
  assign m_tuser  = {o_sat[o_beat], o_dive, o_beat};
  assign m_tlast  = last_beat;

endmodule

[sv/quaternion_arithmetic_unit.sv]
// Every command takes the same path from input transfer to first result:
// front end, square root, both dividers and the output register.
// Throughput: one item per cycle while the output accepts; a matrix command
// takes four output transfers and holds the input until its last row is taken.
// Depth is set by the square root (33 stages) and the two dividers.
// Reset clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
// Add, Hamilton product, conjugate, normalise, inverse and rotation matrix
// on signed fixed-point quaternions, fully pipelined.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [255:0] s_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  input  logic [2:0]   s_tuser,   // cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // lane0, lane1, lane2, lane3
  output logic [3:0]   m_tuser,   // row[1:0], div_error, saturated
  output logic         m_tlast
);
  import qau_pkg::*;

  localparam int QW1 = FRAC_BITS + 1;
  localparam int NW1 = LW + FRAC_BITS;
  localparam int QW2 = 2 * FRAC_BITS + 1;
  localparam int NW2 = ((2 * FRAC_BITS + 1) > LW ? 2 * FRAC_BITS + 1 : LW) + 1;
  localparam int SW2 = $bits(div_side_t) + 4 * QW1;

  logic en;

  logic           f_vld;
  cmd_t           f_cmd;
  rows3_t         f_fast;
  logic [2:0]     f_sat;
  logic [SQW-1:0] f_s;
  comp_t          f_comp;

  root_side_t     rs_in, rs_out;
  logic           r_vld;
  logic [NRW-1:0] r_root;

  div_side_t          ds1_in, ds1_out;
  logic [3:0][NW1-1:0] num1;
  logic [NRW:0]       mag [4];
  logic               d1_vld;
  logic [3:0][QW1-1:0] q1;
  logic [NRW-1:0]     den1;

  logic [SW2-1:0]     s2_in, s2_out;
  logic [3:0][NW2-1:0] num2;
  logic               d2_vld;
  logic [3:0][QW2-1:0] q2;
  logic [NRW-1:0]     den2;

  qau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (s_tvalid && s_tready),
    .in_cmd (s_tuser),
    .in_a   (s_tdata[127:0]),
    .in_b   (s_tdata[255:128]),
    .o_vld  (f_vld),
    .o_cmd  (f_cmd),
    .o_fast (f_fast),
    .o_sat  (f_sat),
    .o_s    (f_s),
    .o_comp (f_comp)
  );

  always_comb begin
    rs_in.cmd  = f_cmd;
    rs_in.sat  = f_sat;
    rs_in.fast = f_fast;
    rs_in.comp = f_comp;
  end

  qau_sqrt #(.IW(SQW), .SW($bits(root_side_t))) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (f_vld),
    .in_s     (f_s),
    .in_side  (rs_in),
    .out_vld  (r_vld),
    .out_root (r_root),
    .out_side (rs_out)
  );

  // |c| * 2^F + N/2
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      mag[l]       = rs_out.comp[l][NRW-1] ? -{1'b1, rs_out.comp[l]} : {1'b0, rs_out.comp[l]};
      num1[l]      = (NW1'(mag[l][LW-1:0]) << FRAC_BITS) + NW1'(r_root >> 1);
      ds1_in.neg[l] = rs_out.comp[l][NRW-1];
    end
    ds1_in.cmd  = rs_out.cmd;
    ds1_in.sat  = rs_out.sat;
    ds1_in.fast = rs_out.fast;
  end

  qau_div #(.NW(NW1), .QW(QW1), .DW(NRW), .SW($bits(div_side_t))) u_div1 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (r_vld),
    .in_num   (num1),
    .in_den   (r_root),
    .in_side  (ds1_in),
    .out_vld  (d1_vld),
    .out_q    (q1),
    .out_den  (den1),
    .out_side (ds1_out)
  );

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      num2[l] = (NW2'(q1[l]) << FRAC_BITS) + NW2'(den1 >> 1);
    end
  end

  assign s2_in = {ds1_out, q1};

  qau_div #(.NW(NW2), .QW(QW2), .DW(NRW), .SW(SW2)) u_div2 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (d1_vld),
    .in_num   (num2),
    .in_den   (den1),
    .in_side  (s2_in),
    .out_vld  (d2_vld),
    .out_q    (q2),
    .out_den  (den2),
    .out_side (s2_out)
  );

  qau_out #(.FRAC_BITS(FRAC_BITS), .QW1(QW1), .QW2(QW2)) u_out (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (d2_vld),
    .in_side  (s2_out[SW2-1 -: $bits(div_side_t)]),
    .in_den   (den2),
    .in_q1    (s2_out[4*QW1-1:0]),
    .in_q2    (q2),
    .adv      (en),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  assign s_tready = en;

  // zero norm gives a single all-zero result
  a_div_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tlast && (m_tdata == '0) && (m_tuser[1:0] == 2'd0)
      && !m_tuser[3])
    else $error("div_error result not zero");

  // matrix rows leave back to back in order
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid
      && (m_tuser[1:0] == $past(m_tuser[1:0]) + 2'd1))
    else $error("matrix row sequence broken");

  // last matrix row is (0, 0, 0, 1.0)
  a_row3: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] == 2'd3) |-> m_tlast
      && (m_tdata == {LW'(1) << FRAC_BITS, {(3*LW){1'b0}}}))
    else $error("matrix row 3 wrong");

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit testbench
// Directed table then random commands on the input stream; every output
// transfer is compared with a predicted result queue. Random idling on both
// sides, plus one long output hold-off to back the pipeline up.
// ----------------------------------------------------------------------------
module tb_top;
  import qau_pkg::*;

  localparam int FB  = 16;
  localparam int LAT = 3 * FB + 40;

  typedef struct {
    logic [2:0]           cmd;
    logic signed [31:0]   a [4];
    logic signed [31:0]   b [4];
  } qcmd_t;

  typedef struct {
    logic [31:0] lane [4];
    logic [1:0]  row;
    logic        last;
    logic        dive;
    logic        sat;
  } qres_t;

  typedef struct {
    qcmd_t c;
    logic  known;
    qres_t r;
  } row_t;

  logic         clk, rst;
  logic         s_tvalid, s_tready;
  logic [255:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid, m_tready;
  logic [127:0] m_tdata;
  logic [3:0]   m_tuser;
  logic         m_tlast;

  quaternion_arithmetic_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  qres_t expected_q[$];
  int    errors;
  int    send_idle, recv_stall;
  bit    hold_off;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("quaternion_arithmetic_unit regression: fail");
    $finish;
  end

  // exact sum rounded half up
  function automatic logic signed [127:0] rnd_sum(logic signed [127:0] s);
    return (s + (128'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic logic signed [127:0] div_rnd(logic signed [127:0] num,
                                                  logic [127:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [127:0] isqrt(logic [127:0] s);
    logic [127:0] r;
    logic [127:0] bt;
    r = 0;
    bt = 128'd1 << 66;
    while (bt > s) bt >>= 2;
    while (bt != 0) begin
      if (s >= r + bt) begin
        s = s - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic qres_t make_res(logic signed [127:0] l [4], logic [1:0] row,
                                     logic last, logic dive);
    qres_t r;
    r.sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (l[i] > 128'sd2147483647) begin
        r.lane[i] = 32'h7fffffff;
        r.sat = 1'b1;
      end else if (l[i] < -128'sd2147483648) begin
        r.lane[i] = 32'h80000000;
        r.sat = 1'b1;
      end else begin
        r.lane[i] = l[i][31:0];
      end
    end
    r.row = row;
    r.last = last;
    r.dive = dive;
    return r;
  endfunction

  task automatic predict_quat(qcmd_t c);
    logic signed [127:0] a [4];
    logic signed [127:0] b [4];
    logic signed [127:0] l [4];
    logic signed [127:0] w, x, y, z, one;
    logic [127:0] s, n;
    for (int i = 0; i < 4; i++) begin
      a[i] = c.a[i];
      b[i] = c.b[i];
    end
    w = a[0]; x = a[1]; y = a[2]; z = a[3];
    one = 128'sd1 <<< (2 * FB);
    case (c.cmd)
      CMD_ADD: begin
        for (int i = 0; i < 4; i++) l[i] = a[i] + b[i];
        expected_q.push_back(make_res(l, 2'd0, 1'b1, 1'b0));
      end
      CMD_MUL: begin
        l[0] = rnd_sum(w*b[0] - x*b[1] - y*b[2] - z*b[3]);
        l[1] = rnd_sum(w*b[1] + x*b[0] + y*b[3] - z*b[2]);
        l[2] = rnd_sum(w*b[2] - x*b[3] + y*b[0] + z*b[1]);
        l[3] = rnd_sum(w*b[3] + x*b[2] - y*b[1] + z*b[0]);
        expected_q.push_back(make_res(l, 2'd0, 1'b1, 1'b0));
      end
      CMD_CONJ: begin
        l[0] = w; l[1] = -x; l[2] = -y; l[3] = -z;
        expected_q.push_back(make_res(l, 2'd0, 1'b1, 1'b0));
      end
      CMD_NORM, CMD_INV: begin
        s = w*w + x*x + y*y + z*z;
        n = isqrt(s);
        if (n == 0) begin
          for (int i = 0; i < 4; i++) l[i] = 0;
          expected_q.push_back(make_res(l, 2'd0, 1'b1, 1'b1));
        end else begin
          for (int i = 0; i < 4; i++) begin
            l[i] = div_rnd(((c.cmd == CMD_INV && i > 0) ? -a[i] : a[i]) <<< FB, n);
            if (c.cmd == CMD_INV) l[i] = div_rnd(l[i] <<< FB, n);
          end
          expected_q.push_back(make_res(l, 2'd0, 1'b1, 1'b0));
        end
      end
      CMD_MAT: begin
        l[0] = rnd_sum(one - 2*y*y - 2*z*z);
        l[1] = rnd_sum(2*x*y - 2*w*z);
        l[2] = rnd_sum(2*x*z + 2*w*y);
        l[3] = 0;
        expected_q.push_back(make_res(l, 2'd0, 1'b0, 1'b0));
        l[0] = rnd_sum(2*x*y + 2*w*z);
        l[1] = rnd_sum(one - 2*x*x - 2*z*z);
        l[2] = rnd_sum(2*y*z - 2*w*x);
        expected_q.push_back(make_res(l, 2'd1, 1'b0, 1'b0));
        l[0] = rnd_sum(2*x*z - 2*w*y);
        l[1] = rnd_sum(2*y*z + 2*w*x);
        l[2] = rnd_sum(one - 2*x*x - 2*y*y);
        expected_q.push_back(make_res(l, 2'd2, 1'b0, 1'b0));
        l[0] = 0; l[1] = 0; l[2] = 0; l[3] = 128'sd1 <<< FB;
        expected_q.push_back(make_res(l, 2'd3, 1'b1, 1'b0));
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_quat(qcmd_t c);
    logic [255:0] d;
    for (int i = 0; i < 4; i++) begin
      d[32*i +: 32] = c.a[i];
      d[32*(i+4) +: 32] = c.b[i];
    end
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= c.cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_quat(c);
  endtask

  // output side: random stall, or held off entirely
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !hold_off && ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    qres_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transfer", m_tdata[63:0], 64'd0);
      end else begin
        e = expected_q.pop_front();
        for (int i = 0; i < 4; i++)
          if (m_tdata[32*i +: 32] !== e.lane[i])
            report_mismatch($sformatf("lane%0d", i), m_tdata[32*i +: 32], e.lane[i]);
        if (m_tuser[1:0] !== e.row) report_mismatch("row", m_tuser[1:0], e.row);
        if (m_tuser[2] !== e.dive) report_mismatch("div_error", m_tuser[2], e.dive);
        if (m_tuser[3] !== e.sat) report_mismatch("saturated", m_tuser[3], e.sat);
        if (m_tlast !== e.last) report_mismatch("last", m_tlast, e.last);
      end
    end
  end

  function automatic logic [31:0] rnd_comp();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h80000000;
      2: return 32'h7fffffff;
      3: return 32'd0;
      default: return $signed($urandom_range(131072)) - 65536;
    endcase
  endfunction

  task automatic run_random(int count, int idle, int stall);
    qcmd_t c;
    send_idle = idle;
    recv_stall = stall;
    for (int k = 0; k < count; k++) begin
      c.cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
      for (int i = 0; i < 4; i++) begin
        c.a[i] = rnd_comp();
        c.b[i] = rnd_comp();
      end
      if ($urandom_range(9) == 0) for (int i = 0; i < 4; i++) c.a[i] = 0;
      send_quat(c);
    end
  endtask

  row_t dir_tab[$];

  task automatic add_row(logic [2:0] cmd, logic [31:0] av, logic [31:0] bv,
                         logic known, logic [31:0] l0, logic dv, logic sv);
    row_t t;
    t.c.cmd = cmd;
    for (int i = 0; i < 4; i++) begin
      t.c.a[i] = av;
      t.c.b[i] = bv;
    end
    t.known = known;
    t.r.lane[0] = l0;
    for (int i = 1; i < 4; i++) t.r.lane[i] = l0;
    t.r.row = 2'd0;
    t.r.last = 1'b1;
    t.r.dive = dv;
    t.r.sat = sv;
    dir_tab.push_back(t);
  endtask

  initial begin
    int cyc;
    errors = 0;
    hold_off = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_ADD;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    add_row(CMD_ADD,  32'h7fffffff, 32'h7fffffff, 1, 32'h7fffffff, 0, 1);
    add_row(CMD_ADD,  32'h80000000, 32'h80000000, 1, 32'h80000000, 0, 1);
    add_row(CMD_ADD,  32'h00010000, 32'hffff0000, 1, 32'h0, 0, 0);
    add_row(CMD_NORM, 32'h0, 32'h0, 1, 32'h0, 1, 0);
    add_row(CMD_INV,  32'h0, 32'h0, 1, 32'h0, 1, 0);
    add_row(CMD_MUL,  32'h80000000, 32'h80000000, 0, 0, 0, 0);
    add_row(CMD_MUL,  32'h7fffffff, 32'h80000000, 0, 0, 0, 0);
    add_row(CMD_MUL,  32'h00018000, 32'hffff4000, 0, 0, 0, 0);
    add_row(CMD_CONJ, 32'h80000000, 32'h0, 0, 0, 0, 0);
    add_row(CMD_CONJ, 32'h7fffffff, 32'h0, 0, 0, 0, 0);
    add_row(CMD_NORM, 32'h80000000, 32'h0, 0, 0, 0, 0);
    add_row(CMD_NORM, 32'h00000001, 32'h0, 0, 0, 0, 0);
    add_row(CMD_INV,  32'h80000000, 32'h0, 0, 0, 0, 0);
    add_row(CMD_INV,  32'h00000001, 32'h0, 0, 0, 0, 0);
    add_row(CMD_INV,  32'h00008000, 32'h0, 0, 0, 0, 0);
    add_row(CMD_MAT,  32'h00008000, 32'h0, 0, 0, 0, 0);
    add_row(CMD_MAT,  32'h80000000, 32'h0, 0, 0, 0, 0);
    add_row(CMD_MAT,  32'h7fffffff, 32'h0, 0, 0, 0, 0);
    add_row(3'd6,     32'h12345678, 32'h0, 0, 0, 0, 0);
    add_row(3'd7,     32'h12345678, 32'h0, 0, 0, 0, 0);
    add_row(CMD_ADD,  32'h5a5a5a5a, 32'ha5a5a5a5, 0, 0, 0, 0);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].known) begin
        send_quat(dir_tab[k].c);
        void'(expected_q.pop_back());
        expected_q.push_back(dir_tab[k].r);
      end else begin
        send_quat(dir_tab[k].c);
      end
    end

    run_random(40, 0, 0);
    run_random(40, 61, 0);
    run_random(30, 0, 61);
    run_random(30, 33, 33);

    // long hold-off on the output while input keeps coming
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      run_random(110, 0, 0);
    join
    s_tvalid <= 1'b0;

    cyc = 0;
    while (expected_q.size() != 0 && cyc < 200000) begin
      @(posedge clk);
      cyc++;
    end
    repeat (LAT + 20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("quaternion_arithmetic_unit regression: pass");
    else
      $display("quaternion_arithmetic_unit regression: fail");
    $finish;
  end

endmodule
